/* sv/page_frame_bitmap_allocator_macros.svh */
// Assertion macros used by the page frame allocator controller.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define PFBA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfba assertion failed");

// Next-cycle implication, quiet while reset is high.
`define PFBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfba assertion failed");

`endif

/* sv/pfba_pkg.sv */
// Shared constants, codes, command/status structs and helpers of the page frame allocator.
// Depends on nothing.
`timescale 1ns / 1ps

package pfba_pkg;

   localparam int FRAMES  = 256;
   localparam int WORD_W  = 32;
   localparam int BIT_W   = $clog2(WORD_W);
   localparam int WORDS   = (FRAMES + WORD_W - 1) / WORD_W;
   localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W   = 9;
   localparam int GRANT_W = 8;
   localparam int COUNT_W = 9;
   localparam int STAT_W  = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;
   localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd3;

   typedef struct packed {
      logic load;
      logic scan;
      logic alloc_hit;
      logic alloc_miss;
      logic free_exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic word_has_free;
      logic last_word;
   } dp_status_type;

   // Bits of word w that lie past the last frame; they read as used.
   function automatic logic [WORD_W-1:0] word_pad(input logic [WIDX_W-1:0] w);
      logic [WORD_W-1:0] m;
      logic [31:0]       base;
      base = 32'(w) * 32'(WORD_W);
      for (int b = 0; b < WORD_W; b++) begin
         m[b] = (base + 32'(b)) >= 32'(FRAMES);
      end
      return m;
   endfunction

endpackage

/* sv/pfba_ctrl.sv */
// Controller of the page frame allocator: sequences load, word scan and commit.
// Depends on pfba_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "page_frame_bitmap_allocator_macros.svh"

module pfba_ctrl
   import pfba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_command,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FREE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl_cmd.load = 1'b1;
               state_in = (req_command == CMD_FREE) ? S_FREE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (dp_status.word_has_free) begin
               ctrl_cmd.alloc_hit = 1'b1;
               state_in = S_IDLE;
            end else if (dp_status.last_word) begin
               ctrl_cmd.alloc_miss = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctrl_cmd.scan = 1'b1;
            end
         end
         S_FREE: begin
            ctrl_cmd.free_exec = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign strobe_in  = ctrl_cmd.alloc_hit || ctrl_cmd.alloc_miss || ctrl_cmd.free_exec;
   assign rsp_strobe = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   `PFBA_ASSERT_NEXT(a_accept_goes_busy, accept, busy)
   `PFBA_ASSERT_NEXT(a_strobe_single, strobe_ff, !strobe_ff)
   `PFBA_ASSERT_NEXT(a_free_one_cycle, state_ff == S_FREE, state_ff == S_IDLE && strobe_ff)
   `PFBA_ASSERT_NEXT(a_scan_continues,
      state_ff == S_SCAN && !dp_status.word_has_free && !dp_status.last_word,
      state_ff == S_SCAN && !strobe_ff)

endmodule

/* sv/pfba_datapath.sv */
// Datapath of the page frame allocator: used-mark words, find-first-zero, count, result regs.
// Depends on pfba_pkg.
`timescale 1ns / 1ps

module pfba_datapath
   import pfba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        ctrl_cmd,
   input  logic                req_command,
   input  logic [IDX_W-1:0]    req_frame_to_free,
   output dp_status_type       dp_status,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [GRANT_W-1:0]  rsp_granted_frame,
   output logic [COUNT_W-1:0]  rsp_frames_in_use
);

   logic [WORD_W-1:0]  bitmap_ff [WORDS];
   logic [WIDX_W-1:0]  word_ff, word_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [GRANT_W-1:0] granted_ff, granted_in;
   logic [COUNT_W-1:0] inuse_ff;

   logic [WORD_W-1:0]  raw_word, padded_word, word_wr;
   logic               word_we;
   logic [BIT_W-1:0]   ffz_bit;
   logic [31:0]        frame_full;
   logic [31:0]        load_word;
   logic               free_ok;

   assign raw_word    = bitmap_ff[word_ff];
   assign padded_word = raw_word | word_pad(word_ff);

   // Lowest clear bit of the current word.
   always_comb begin
      ffz_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!padded_word[b]) begin
            ffz_bit = BIT_W'(b);
         end
      end
   end

   assign dp_status.word_has_free = ~&padded_word;
   assign dp_status.last_word     = (word_ff == WIDX_W'(WORDS - 1));

   assign frame_full = (32'(word_ff) << BIT_W) | 32'(ffz_bit);
   assign load_word  = 32'(req_frame_to_free) >> BIT_W;
   assign free_ok    = (32'(idx_ff) < 32'(FRAMES)) && raw_word[idx_ff[BIT_W-1:0]];

   always_comb begin
      word_in    = word_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      word_wr    = raw_word;
      word_we    = 1'b0;
      if (ctrl_cmd.load) begin
         word_in = (req_command == CMD_FREE) ? load_word[WIDX_W-1:0] : '0;
      end
      if (ctrl_cmd.scan) begin
         word_in = word_ff + 1'b1;
      end
      if (ctrl_cmd.alloc_hit) begin
         word_wr          = raw_word;
         word_wr[ffz_bit] = 1'b1;
         word_we          = 1'b1;
         count_in         = count_ff + 1'b1;
         status_in        = ST_ALLOCATED;
         granted_in       = frame_full[GRANT_W-1:0];
      end
      if (ctrl_cmd.alloc_miss) begin
         status_in  = ST_EXHAUSTED;
         granted_in = '0;
      end
      if (ctrl_cmd.free_exec) begin
         granted_in = '0;
         if (free_ok) begin
            word_wr                     = raw_word;
            word_wr[idx_ff[BIT_W-1:0]]  = 1'b0;
            word_we                     = 1'b1;
            count_in                    = count_ff - 1'b1;
            status_in                   = ST_FREED;
         end else begin
            status_in = ST_IGNORED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int w = 0; w < WORDS; w++) begin
            bitmap_ff[w] <= '0;
         end
      end else begin
         count_ff <= count_in;
         if (word_we) begin
            bitmap_ff[word_ff] <= word_wr;
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      inuse_ff   <= count_in;
      if (ctrl_cmd.load) begin
         idx_ff <= req_frame_to_free;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_frame = granted_ff;
   assign rsp_frames_in_use = inuse_ff;

endmodule

/* sv/page_frame_bitmap_allocator.sv */
// First-fit page frame allocator with a used-mark bitmap, top level.
// Depends on pfba_pkg, pfba_ctrl and pfba_datapath.
//
// A command is taken when start is high and busy is low; its one result
// appears on the rsp_ ports for a single cycle with rsp_strobe high and
// cannot be held off, so capture it then. A free passes through the S_FREE
// state before its strobe is registered. An allocate steps the find-first-zero
// unit through the 32-bit bitmap words, one word per cycle, from the first
// word until it meets a free frame or the last word, so 1 to 8 words are scanned.
// A new command may be started in the cycle its predecessor's result is
// strobed. The bitmap and the used count are cleared by reset.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator
   import pfba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [IDX_W-1:0]    req_frame_to_free,
   output logic                rsp_strobe,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [GRANT_W-1:0]  rsp_granted_frame,
   output logic [COUNT_W-1:0]  rsp_frames_in_use
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   pfba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .dp_status   (dp_status),
      .ctrl_cmd    (ctrl_cmd),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   pfba_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl_cmd          (ctrl_cmd),
      .req_command       (req_command),
      .req_frame_to_free (req_frame_to_free),
      .dp_status         (dp_status),
      .rsp_status        (rsp_status),
      .rsp_granted_frame (rsp_granted_frame),
      .rsp_frames_in_use (rsp_frames_in_use)
   );

endmodule
